### rtl/stack_permutation_checker_macros.svh
`ifndef STACK_PERMUTATION_CHECKER_MACROS_SVH
`define STACK_PERMUTATION_CHECKER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SPC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define SPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/spc_pkg.sv
`timescale 1ns / 1ps
package spc_pkg;

    localparam int CAR_W        = 11;
    localparam int DEF_MAX_CARS = 1024;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_PUSH,
        ST_FINISH
    } t_state;

endpackage

### rtl/spc_stack_ram.sv
`timescale 1ns / 1ps
module spc_stack_ram import spc_pkg::*; #(
    parameter int DEPTH = DEF_MAX_CARS,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [CAR_W-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [CAR_W-1:0]  o_rd_data
);

    logic [CAR_W-1:0] r_mem [DEPTH];
    logic [CAR_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/stack_permutation_checker.sv
`timescale 1ns / 1ps
`include "stack_permutation_checker_macros.svh"
// Checks, one requested car per item, whether a departure order can be
// produced by passing cars 1..train_length through a last-in first-out
// station. Each item gives one result: still_feasible and order_done. An item
// passes through accept, evaluate, one push step for every car pushed onto
// the station, and hand to the output register; each car is pushed at most
// once per order. The push loop runs through the station memory, one write
// per cycle, and the stack top comes from that memory's registered read
// port. The block is stalled while an item is in work; it can take the next
// item while a result still waits in the output register. train_length is
// written through its own port, always ready, and must only change while
// the block is idle.
module stack_permutation_checker import spc_pkg::*; #(
    parameter int MAX_CARS = DEF_MAX_CARS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CAR_W-1:0] i_cfg_train_length,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [CAR_W-1:0] i_car_number,
    input  logic             i_first_of_order,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_still_feasible,
    output logic             o_order_done
);

    localparam int ADDR_W = $clog2(MAX_CARS);
    localparam int CNT_W  = $clog2(MAX_CARS + 1);
    localparam int NA_W   = CAR_W + 1;

    t_state r_state, n_state;

    logic [CAR_W-1:0]  r_train_length;
    logic [CAR_W-1:0]  r_car, n_car;
    logic              r_done, n_done;
    logic [NA_W-1:0]   r_next_arr, n_next_arr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_failed, n_failed;
    logic [CAR_W-1:0]  r_seen, n_seen;
    logic              r_out_valid, n_out_valid;
    logic              r_out_feas, n_out_feas;
    logic              r_out_done, n_out_done;

    logic [CAR_W-1:0]  eff_len;
    logic              in_accept;
    logic              out_free;
    logic              active;
    logic              car_bad;
    logic              car_ahead;
    logic              need_push;
    logic              last_push;
    logic              wr_en;
    logic [CAR_W-1:0]  rd_data;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;

    // length clamped to 1..MAX_CARS
    always_comb begin
        if (r_train_length == '0) begin
            eff_len = CAR_W'(1);
        end else if (32'(r_train_length) > MAX_CARS) begin
            eff_len = CAR_W'(MAX_CARS);
        end else begin
            eff_len = r_train_length;
        end
    end

    assign active    = r_seen < eff_len;
    assign car_bad   = (r_car == '0) || (r_car > eff_len);
    assign car_ahead = {1'b0, r_car} >= r_next_arr;
    assign need_push = {1'b0, r_car} > r_next_arr;
    assign last_push = (r_next_arr + NA_W'(1)) == {1'b0, r_car};
    assign wr_en     = (r_state == ST_PUSH) && (r_count < CNT_W'(MAX_CARS));

    spc_stack_ram #(
        .DEPTH (MAX_CARS)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data (r_next_arr[CAR_W-1:0]),
        .i_rd_addr (ADDR_W'(r_count - CNT_W'(1))),
        .o_rd_data (rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (active && !r_failed && !car_bad && need_push) begin
                    n_state = ST_PUSH;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_PUSH: begin
                if (last_push) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_car       = r_car;
        n_done      = r_done;
        n_next_arr  = r_next_arr;
        n_count     = r_count;
        n_failed    = r_failed;
        n_seen      = r_seen;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_feas  = r_out_feas;
        n_out_done  = r_out_done;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_car = i_car_number;
                    if (i_first_of_order) begin
                        n_next_arr = NA_W'(1);
                        n_count    = '0;
                        n_failed   = 1'b0;
                        n_seen     = '0;
                    end
                end
            end
            ST_EVAL: begin
                n_done = 1'b0;
                if (active) begin
                    n_seen = r_seen + CAR_W'(1);
                    n_done = (r_seen + CAR_W'(1)) == eff_len;
                    if (!r_failed) begin
                        if (car_bad) begin
                            n_failed = 1'b1;
                        end else if (car_ahead) begin
                            if (!need_push) begin
                                n_next_arr = {1'b0, r_car} + NA_W'(1);
                            end
                        end else if ((r_count != '0) && (rd_data == r_car)) begin
                            n_count = r_count - CNT_W'(1);
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                end
            end
            ST_PUSH: begin
                if (wr_en) begin
                    n_count = r_count + CNT_W'(1);
                end
                if (last_push) begin
                    n_next_arr = {1'b0, r_car} + NA_W'(1);
                end else begin
                    n_next_arr = r_next_arr + NA_W'(1);
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_feas  = !r_failed;
                    n_out_done  = r_done;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_train_length <= CAR_W'(1);
            r_next_arr     <= NA_W'(1);
            r_count        <= '0;
            r_failed       <= 1'b0;
            r_seen         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next_arr  <= n_next_arr;
            r_count     <= n_count;
            r_failed    <= n_failed;
            r_seen      <= n_seen;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_train_length <= i_cfg_train_length;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_car      <= n_car;
        r_done     <= n_done;
        r_out_feas <= n_out_feas;
        r_out_done <= n_out_done;
    end

    assign o_cfg_ready      = 1'b1;
    assign o_in_stall       = r_state != ST_IDLE;
    assign o_out_valid      = r_out_valid;
    assign o_still_feasible = r_out_feas;
    assign o_order_done     = r_out_done;

    `SPC_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_CARS), "stack count above depth")
    `SPC_ASSERT_NEXT(a_accept_eval, i_clk, i_rst_n, in_accept, r_state == ST_EVAL, "accepted item not evaluated")
    `SPC_ASSERT_IMPL(a_push_below, i_clk, i_rst_n, r_state == ST_PUSH, r_next_arr < {1'b0, r_car}, "push past requested car")
    `SPC_ASSERT_NEXT(a_finish_load, i_clk, i_rst_n, (r_state == ST_FINISH) && out_free, o_out_valid, "result not loaded")

endmodule
